FILE: rtl/tree_lca_distance_engine_unit_macros.svh
// Assertion macros used by the checker file of this block.
// Every macro expects signals named clk and rst_n in the scope where it is used.
`ifndef TREE_LCA_DISTANCE_ENGINE_UNIT_MACROS_SVH
`define TREE_LCA_DISTANCE_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define TLCA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define TLCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that stays on during reset.
`define TLCA_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tlca_pkg.sv
package tlca_pkg;

  // Tree size and lifting depth.
  localparam int NODE_SLOTS   = 1024;
  localparam int LIFT_LEVELS  = 10;
  localparam int NODE_W       = $clog2(NODE_SLOTS);
  localparam int LVL_W        = $clog2(LIFT_LEVELS);
  localparam int ANC_DEPTH    = NODE_SLOTS * LIFT_LEVELS;
  localparam int ANC_AW       = $clog2(ANC_DEPTH);

  // Fixed field widths of the stream words.
  localparam int NODE_FIELD_W = 10;
  localparam int DEPTH_W      = 10;
  localparam int DIST_W       = 11;
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 16;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [LVL_W-1:0]   lvl_t;
  typedef logic [ANC_AW-1:0]  anc_addr_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [DIST_W-1:0]  dist_t;

  localparam depth_t DEPTH_MAX = '1;
  localparam lvl_t   LVL_TOP   = lvl_t'(LIFT_LEVELS - 1);
  localparam node_t  ROOT_NODE = node_t'(1);

  // Request kinds carried in tuser.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_DEP,
    S_INS_RD,
    S_INS_WR,
    S_Q_DEP,
    S_Q_ORD,
    S_P1_ANC,
    S_P1_DEP,
    S_P2,
    S_MEET_A,
    S_MEET_D,
    S_RES
  } state_t;

  // Port bundle from the sequencer to the ancestor RAM.
  typedef struct packed {
    logic      we;
    anc_addr_t waddr;
    node_t     wdata;
    anc_addr_t raddr0;
    anc_addr_t raddr1;
  } anc_req_t;

  // Port bundle from the sequencer to the depth RAM.
  typedef struct packed {
    logic   we;
    node_t  waddr;
    depth_t wdata;
    node_t  raddr0;
    node_t  raddr1;
  } dep_req_t;

  // Row-major location of level lvl of a node's ancestor row.
  function automatic anc_addr_t anc_addr(node_t node, lvl_t lvl);
    return anc_addr_t'(node) * anc_addr_t'(LIFT_LEVELS) + anc_addr_t'(lvl);
  endfunction

endpackage

FILE: rtl/tlca_ram.sv
module tlca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

FILE: rtl/tlca_core.sv
module tlca_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_type,
  input  logic [tlca_pkg::NODE_FIELD_W-1:0] in_a,
  input  logic [tlca_pkg::NODE_FIELD_W-1:0] in_b,
  output logic                            res_valid,
  input  logic                            res_ready,
  output tlca_pkg::dist_t                 res_dist,
  output tlca_pkg::anc_req_t              anc_req,
  input  tlca_pkg::node_t                 anc_q0,
  input  tlca_pkg::node_t                 anc_q1,
  output tlca_pkg::dep_req_t              dep_req,
  input  tlca_pkg::depth_t                dep_q0,
  input  tlca_pkg::depth_t                dep_q1
);

  tlca_pkg::state_t state_r, state_nxt;

  tlca_pkg::node_t  a_r, a_nxt, b_r, b_nxt;
  tlca_pkg::node_t  w_r, w_nxt, up_r, up_nxt;
  tlca_pkg::node_t  deep_r, deep_nxt, shal_r, shal_nxt;
  tlca_pkg::lvl_t   k_r, k_nxt;
  tlca_pkg::depth_t da_r, da_nxt, db_r, db_nxt, dshal_r, dshal_nxt;
  tlca_pkg::dist_t  dist_r, dist_nxt;

  // Flags that make the root and the sentinel read as zero.
  logic z_a0_r, z_a1_r, z_d0_r, z_d1_r;

  tlca_pkg::node_t  ra0_node, ra1_node, rd0_node, rd1_node;
  tlca_pkg::lvl_t   ra0_lvl, ra1_lvl;
  tlca_pkg::node_t  in_a_slot, in_b_slot;

  tlca_pkg::node_t  a0, a1;
  tlca_pkg::depth_t d0, d1;
  logic             k_last;
  tlca_pkg::lvl_t   k_dn;
  logic             p1_take, p2_diff, q_lt;
  tlca_pkg::node_t  p1_deep, p2_deep, p2_shal;
  tlca_pkg::depth_t ins_depth;

  assign in_a_slot = in_a[tlca_pkg::NODE_W-1:0];
  assign in_b_slot = in_b[tlca_pkg::NODE_W-1:0];

  // Read data with the root and sentinel rows forced to zero.
  assign a0 = z_a0_r ? '0 : anc_q0;
  assign a1 = z_a1_r ? '0 : anc_q1;
  assign d0 = z_d0_r ? '0 : dep_q0;
  assign d1 = z_d1_r ? '0 : dep_q1;

  // Shared compare unit: level count, depth order and lift decisions.
  assign k_last    = (k_r == '0);
  assign k_dn      = k_last ? '0 : k_r - tlca_pkg::lvl_t'(1);
  assign q_lt      = (d0 < d1);
  assign p1_take   = (d0 >= dshal_r);
  assign p1_deep   = p1_take ? up_r : deep_r;
  assign p2_diff   = (a0 != a1);
  assign p2_deep   = p2_diff ? a0 : deep_r;
  assign p2_shal   = p2_diff ? a1 : shal_r;
  assign ins_depth = (d1 >= tlca_pkg::DEPTH_MAX) ? tlca_pkg::DEPTH_MAX
                                                 : d1 + tlca_pkg::depth_t'(1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlca_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_type == tlca_pkg::REQ_QUERY) begin
            state_nxt = tlca_pkg::S_Q_DEP;
          end else if (in_a_slot[tlca_pkg::NODE_W-1:1] != '0) begin
            state_nxt = tlca_pkg::S_INS_DEP;
          end
        end
      end
      tlca_pkg::S_INS_DEP: state_nxt = tlca_pkg::S_INS_RD;
      tlca_pkg::S_INS_RD:  state_nxt = tlca_pkg::S_INS_WR;
      tlca_pkg::S_INS_WR: begin
        state_nxt = (k_r == tlca_pkg::LVL_TOP) ? tlca_pkg::S_IDLE : tlca_pkg::S_INS_RD;
      end
      tlca_pkg::S_Q_DEP: begin
        if (a_r == tlca_pkg::ROOT_NODE || b_r == tlca_pkg::ROOT_NODE) begin
          state_nxt = tlca_pkg::S_RES;
        end else begin
          state_nxt = tlca_pkg::S_Q_ORD;
        end
      end
      tlca_pkg::S_Q_ORD: begin
        if (da_r != db_r) begin
          state_nxt = tlca_pkg::S_P1_ANC;
        end else if (deep_r == shal_r) begin
          state_nxt = tlca_pkg::S_MEET_D;
        end else begin
          state_nxt = tlca_pkg::S_P2;
        end
      end
      tlca_pkg::S_P1_ANC: state_nxt = tlca_pkg::S_P1_DEP;
      tlca_pkg::S_P1_DEP: begin
        if (!k_last) begin
          state_nxt = tlca_pkg::S_P1_ANC;
        end else if (p1_deep == shal_r) begin
          state_nxt = tlca_pkg::S_MEET_D;
        end else begin
          state_nxt = tlca_pkg::S_P2;
        end
      end
      tlca_pkg::S_P2:     state_nxt = k_last ? tlca_pkg::S_MEET_A : tlca_pkg::S_P2;
      tlca_pkg::S_MEET_A: state_nxt = tlca_pkg::S_MEET_D;
      tlca_pkg::S_MEET_D: state_nxt = tlca_pkg::S_RES;
      tlca_pkg::S_RES:    state_nxt = res_ready ? tlca_pkg::S_IDLE : tlca_pkg::S_RES;
      default:            state_nxt = tlca_pkg::S_IDLE;
    endcase
  end

  // Handshakes and RAM requests for each step.
  always_comb begin
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    ra0_node      = deep_r;
    ra0_lvl       = tlca_pkg::LVL_TOP;
    ra1_node      = shal_r;
    ra1_lvl       = tlca_pkg::LVL_TOP;
    rd0_node      = deep_r;
    rd1_node      = shal_r;
    anc_req.we    = 1'b0;
    anc_req.waddr = tlca_pkg::anc_addr(a_r, k_r);
    anc_req.wdata = a0;
    dep_req.we    = 1'b0;
    dep_req.waddr = a_r;
    dep_req.wdata = ins_depth;
    unique case (state_r)
      tlca_pkg::S_IDLE: begin
        in_ready = 1'b1;
        rd0_node = in_a_slot;
        rd1_node = in_b_slot;
      end
      tlca_pkg::S_INS_DEP: begin
        dep_req.we    = 1'b1;
        anc_req.we    = 1'b1;
        anc_req.waddr = tlca_pkg::anc_addr(a_r, '0);
        anc_req.wdata = b_r;
      end
      tlca_pkg::S_INS_RD: begin
        ra0_node = w_r;
        ra0_lvl  = k_r - tlca_pkg::lvl_t'(1);
      end
      tlca_pkg::S_INS_WR: begin
        anc_req.we = 1'b1;
      end
      tlca_pkg::S_P1_ANC: begin
        rd0_node = a0;
      end
      tlca_pkg::S_P1_DEP: begin
        ra0_node = p1_deep;
        ra0_lvl  = k_last ? tlca_pkg::LVL_TOP : k_dn;
        rd0_node = p1_deep;
      end
      tlca_pkg::S_P2: begin
        ra0_node = p2_deep;
        ra0_lvl  = k_dn;
        ra1_node = p2_shal;
        ra1_lvl  = k_dn;
      end
      tlca_pkg::S_MEET_A: begin
        rd0_node = a0;
      end
      tlca_pkg::S_RES: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
    anc_req.raddr0 = tlca_pkg::anc_addr(ra0_node, ra0_lvl);
    anc_req.raddr1 = tlca_pkg::anc_addr(ra1_node, ra1_lvl);
    dep_req.raddr0 = rd0_node;
    dep_req.raddr1 = rd1_node;
  end

  assign res_dist = dist_r;

  // Working registers of the walk.
  always_comb begin
    a_nxt     = a_r;
    b_nxt     = b_r;
    w_nxt     = w_r;
    up_nxt    = up_r;
    deep_nxt  = deep_r;
    shal_nxt  = shal_r;
    k_nxt     = k_r;
    da_nxt    = da_r;
    db_nxt    = db_r;
    dshal_nxt = dshal_r;
    dist_nxt  = dist_r;
    case (state_r)
      tlca_pkg::S_IDLE: begin
        a_nxt = in_a_slot;
        b_nxt = in_b_slot;
      end
      tlca_pkg::S_INS_DEP: begin
        k_nxt = tlca_pkg::lvl_t'(1);
        w_nxt = b_r;
      end
      tlca_pkg::S_INS_WR: begin
        w_nxt = a0;
        k_nxt = k_r + tlca_pkg::lvl_t'(1);
      end
      tlca_pkg::S_Q_DEP: begin
        da_nxt    = d0;
        db_nxt    = d1;
        deep_nxt  = q_lt ? b_r : a_r;
        shal_nxt  = q_lt ? a_r : b_r;
        dshal_nxt = q_lt ? d0 : d1;
        dist_nxt  = tlca_pkg::dist_t'(d0) + tlca_pkg::dist_t'(d1);
      end
      tlca_pkg::S_Q_ORD: begin
        k_nxt = tlca_pkg::LVL_TOP;
      end
      tlca_pkg::S_P1_ANC: begin
        up_nxt = a0;
      end
      tlca_pkg::S_P1_DEP: begin
        deep_nxt = p1_deep;
        k_nxt    = k_last ? tlca_pkg::LVL_TOP : k_dn;
      end
      tlca_pkg::S_P2: begin
        deep_nxt = p2_deep;
        shal_nxt = p2_shal;
        k_nxt    = k_dn;
      end
      tlca_pkg::S_MEET_D: begin
        dist_nxt = tlca_pkg::dist_t'(da_r) + tlca_pkg::dist_t'(db_r)
                 - (tlca_pkg::dist_t'(d0) << 1);
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlca_pkg::S_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  // Payload registers and read-side zero flags.
  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    w_r     <= w_nxt;
    up_r    <= up_nxt;
    deep_r  <= deep_nxt;
    shal_r  <= shal_nxt;
    da_r    <= da_nxt;
    db_r    <= db_nxt;
    dshal_r <= dshal_nxt;
    dist_r  <= dist_nxt;
    z_a0_r  <= (ra0_node[tlca_pkg::NODE_W-1:1] == '0);
    z_a1_r  <= (ra1_node[tlca_pkg::NODE_W-1:1] == '0);
    z_d0_r  <= (rd0_node[tlca_pkg::NODE_W-1:1] == '0);
    z_d1_r  <= (rd1_node[tlca_pkg::NODE_W-1:1] == '0);
  end

endmodule

FILE: rtl/tree_lca_distance_engine_unit.sv
// Tree distance engine using binary lifting over a stored rooted tree.
// Input stream: each word either inserts node_a under parent node_b (tuser = 0)
// or asks for the path length between node_a and node_b (tuser = 1).
// Output stream: one word with the distance for each query, none for an insert.
// Node 1 is the root and node 0 the sentinel; a parent must be inserted first.
// An insert keeps the input closed while it writes the depth and level 0 of the
// ancestor row, then each higher level in turn (read, then write back).
// A query naming the root goes from the depth read straight to the result step;
// any other query, where the depths differ, runs a depth-matching pass (ancestor
// read, then depth read, for each level), then, where the nodes still differ, a
// joint pass, which reads both ancestors at once on the two read ports of the ancestor RAM.
// One item is worked on at a time; the next word is accepted once the previous
// result has moved into the output register, even while that register waits.
// Reset clears the sequencer and the output valid; the RAMs are not cleared, and
// the root and sentinel rows read as zero by construction.
// A stalled receiver holds the output word; a following query then waits in its
// final step until the output register is free.
module tree_lca_distance_engine_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // node_a [9:0], node_b [19:10], zero fill [23:20]
  input  logic [tlca_pkg::IN_TDATA_W-1:0] in_tdata,
  // req_type [0]
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // distance [10:0], zero fill [15:11]
  output logic [tlca_pkg::OUT_TDATA_W-1:0] out_tdata
);

  tlca_pkg::anc_req_t anc_req;
  tlca_pkg::dep_req_t dep_req;
  tlca_pkg::node_t    anc_q0, anc_q1;
  tlca_pkg::depth_t   dep_q0, dep_q1;
  logic               res_valid, res_ready;
  tlca_pkg::dist_t    res_dist;

  logic               out_valid_r, out_valid_nxt;
  tlca_pkg::dist_t    out_dist_r, out_dist_nxt;

  tlca_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_type   (in_tuser),
    .in_a      (in_tdata[tlca_pkg::NODE_FIELD_W-1:0]),
    .in_b      (in_tdata[2*tlca_pkg::NODE_FIELD_W-1:tlca_pkg::NODE_FIELD_W]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_dist  (res_dist),
    .anc_req   (anc_req),
    .anc_q0    (anc_q0),
    .anc_q1    (anc_q1),
    .dep_req   (dep_req),
    .dep_q0    (dep_q0),
    .dep_q1    (dep_q1)
  );

  // Ancestor rows, one entry per node and level.
  tlca_ram #(
    .WIDTH (tlca_pkg::NODE_W),
    .DEPTH (tlca_pkg::ANC_DEPTH)
  ) u_anc_ram (
    .clk    (clk),
    .we     (anc_req.we),
    .waddr  (anc_req.waddr),
    .wdata  (anc_req.wdata),
    .raddr0 (anc_req.raddr0),
    .raddr1 (anc_req.raddr1),
    .rdata0 (anc_q0),
    .rdata1 (anc_q1)
  );

  // Depth of every node.
  tlca_ram #(
    .WIDTH (tlca_pkg::DEPTH_W),
    .DEPTH (tlca_pkg::NODE_SLOTS)
  ) u_dep_ram (
    .clk    (clk),
    .we     (dep_req.we),
    .waddr  (dep_req.waddr),
    .wdata  (dep_req.wdata),
    .raddr0 (dep_req.raddr0),
    .raddr1 (dep_req.raddr1),
    .rdata0 (dep_q0),
    .rdata1 (dep_q1)
  );

  // Output register: takes a result whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_dist_nxt  = out_dist_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_dist_nxt  = res_dist;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dist_r <= out_dist_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(tlca_pkg::OUT_TDATA_W - tlca_pkg::DIST_W)'(0), out_dist_r};

endmodule

FILE: rtl/tlca_checker.sv
`include "tree_lca_distance_engine_unit_macros.svh"

module tlca_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [tlca_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tlca_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;

  // A stalled result word stays valid and unchanged.
  `TLCA_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid, "stalled output word dropped")
  `TLCA_ASSERT_NEXT(a_out_stable, out_stall, $stable(out_tdata), "stalled output changed")

  // Reset empties the output register.
  `TLCA_ASSERT_NEXT_ALWAYS(a_rst_out, !rst_n, !out_tvalid, "output valid after reset")

  // A query closes the input while the walk runs.
  `TLCA_ASSERT_NEXT(a_query_busy, in_acc && in_tuser == tlca_pkg::REQ_QUERY, !in_tready,
                    "input still open after a query")

  // Distances never reach the fill bits.
  `TLCA_ASSERT_SAME(a_out_fill, out_tvalid,
                    out_tdata[tlca_pkg::OUT_TDATA_W-1:tlca_pkg::DIST_W] == '0,
                    "output fill bits set")

endmodule

bind tree_lca_distance_engine_unit tlca_checker u_tlca_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int MAX_SHOWN    = 10;
  localparam int RANDOM_WORDS = 800;
  localparam int LONG_HOLD    = 400;
  localparam int SELF_INSERTS = 60;
  localparam int SETTLE       = 40;

  // Predicts the distance answers of the tree store and checks them in order.
  class dist_scoreboard;
    tlca_pkg::node_t  lift_row [tlca_pkg::NODE_SLOTS][tlca_pkg::LIFT_LEVELS];
    tlca_pkg::depth_t depth_of [tlca_pkg::NODE_SLOTS];
    tlca_pkg::dist_t  dist_due [$];
    int     errors;
    int     checked;
    int     deepest;

    function new();
      for (int n = 0; n < tlca_pkg::NODE_SLOTS; n++) begin
        depth_of[n] = '0;
        for (int k = 0; k < tlca_pkg::LIFT_LEVELS; k++) begin
          lift_row[n][k] = '0;
        end
      end
      errors  = 0;
      checked = 0;
      deepest = 0;
    endfunction

    // Hang a node under its parent; the row is rebuilt in place, level by level.
    function void place_node(tlca_pkg::node_t child, tlca_pkg::node_t parent);
      tlca_pkg::depth_t up;
      tlca_pkg::node_t  mid;
      if (child <= tlca_pkg::ROOT_NODE) return;
      up = depth_of[parent];
      depth_of[child] = (up == tlca_pkg::DEPTH_MAX) ? tlca_pkg::DEPTH_MAX : up + 1'b1;
      if (int'(depth_of[child]) > deepest) deepest = int'(depth_of[child]);
      lift_row[child][0] = parent;
      for (int k = 1; k < tlca_pkg::LIFT_LEVELS; k++) begin
        mid = lift_row[child][k-1];
        lift_row[child][k] = lift_row[mid][k-1];
      end
    endfunction

    // Edge count between two nodes through their lowest common ancestor.
    function tlca_pkg::dist_t path_edges(tlca_pkg::node_t s, tlca_pkg::node_t e);
      tlca_pkg::node_t far, near, meet, ua, ub;
      if (s == tlca_pkg::ROOT_NODE || e == tlca_pkg::ROOT_NODE)
        return tlca_pkg::dist_t'(int'(depth_of[s]) + int'(depth_of[e]));
      far  = s;
      near = e;
      if (depth_of[s] < depth_of[e]) begin
        far  = e;
        near = s;
      end
      // Lift the deeper node to the depth of the other one.
      if (depth_of[far] != depth_of[near]) begin
        for (int k = tlca_pkg::LIFT_LEVELS - 1; k >= 0; k--) begin
          ua = lift_row[far][k];
          if (depth_of[ua] >= depth_of[near]) far = ua;
        end
      end
      // Lift both together while their ancestors differ.
      meet = far;
      if (far != near) begin
        for (int k = tlca_pkg::LIFT_LEVELS - 1; k >= 0; k--) begin
          ua = lift_row[far][k];
          ub = lift_row[near][k];
          if (ua != ub) begin
            far  = ua;
            near = ub;
          end
          meet = lift_row[far][k];
        end
      end
      return tlca_pkg::dist_t'(int'(depth_of[s]) + int'(depth_of[e])
                               - 2 * int'(depth_of[meet]));
    endfunction

    function void note_word(logic kind, tlca_pkg::node_t a, tlca_pkg::node_t b);
      if (kind == tlca_pkg::REQ_INSERT) place_node(a, b);
      else dist_due = {dist_due, path_edges(a, b)};
    endfunction

    function void check_word(tlca_pkg::dist_t got);
      tlca_pkg::dist_t want;
      if (dist_due.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t: distance word %0d arrived with no query waiting", $realtime, got);
        return;
      end
      want = dist_due.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t: distance mismatch, expected %0d, got %0d", $realtime, want, got);
      end
    endfunction

    function int pending();
      return dist_due.size();
    endfunction
  endclass

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [tlca_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                             in_tuser   = tlca_pkg::REQ_INSERT;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [tlca_pkg::OUT_TDATA_W-1:0] out_tdata;

  dist_scoreboard sb = new();

  int              send_idle_pct = 23;
  int              recv_idle_pct = 87;
  int              stall_asks    = 0;
  int              stall_seen    = 0;
  int              hold_left     = 0;
  int              cycle_count   = 0;
  int              insert_words  = 0;
  int              query_words   = 0;
  bit              placed [tlca_pkg::NODE_SLOTS];
  tlca_pkg::node_t placed_q [$];

  tree_lca_distance_engine_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every accepted input word goes to the predictor.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_word(in_tuser,
                   tlca_pkg::node_t'(in_tdata[tlca_pkg::NODE_FIELD_W-1:0]),
                   tlca_pkg::node_t'(in_tdata[2*tlca_pkg::NODE_FIELD_W-1:
                                              tlca_pkg::NODE_FIELD_W]));
      if (in_tuser == tlca_pkg::REQ_QUERY) query_words++;
      else insert_words++;
    end
  end

  // Result side: check accepted words, then choose the next ready level.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_word(tlca_pkg::dist_t'(out_tdata[tlca_pkg::DIST_W-1:0]));
    if (stall_seen != stall_asks) begin
      stall_seen++;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic tlca_pkg::node_t pick_placed();
    return placed_q[$urandom_range(placed_q.size() - 1)];
  endfunction

  // One of the latest nodes, so that chains grow deep.
  function automatic tlca_pkg::node_t pick_recent();
    int n;
    int span;
    n    = placed_q.size();
    span = (n > 8) ? 8 : n;
    return placed_q[n - 1 - $urandom_range(span - 1)];
  endfunction

  // A node not yet in the tree, or zero when every slot is taken.
  function automatic tlca_pkg::node_t pick_fresh();
    tlca_pkg::node_t n;
    if (placed_q.size() >= tlca_pkg::NODE_SLOTS - 1) return '0;
    do n = tlca_pkg::node_t'($urandom_range(tlca_pkg::NODE_SLOTS - 1, 2)); while (placed[n]);
    return n;
  endfunction

  // Offer one word and hold it until the block takes it.
  task automatic send_word(logic kind, tlca_pkg::node_t a, tlca_pkg::node_t b);
    if (kind == tlca_pkg::REQ_INSERT && a > tlca_pkg::ROOT_NODE && !placed[a]) begin
      placed[a] = 1'b1;
      placed_q  = {placed_q, a};
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{(tlca_pkg::IN_TDATA_W - 2*tlca_pkg::NODE_FIELD_W){1'b0}}, b, a};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic pause(int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic maybe_idle();
    if ($urandom_range(99) < send_idle_pct) pause($urandom_range(4, 1));
  endtask

  // Stop sending until every query has been answered.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Mostly tree growth and queries on present nodes, some reshaping noise.
  task automatic random_word();
    int              roll;
    tlca_pkg::node_t a;
    tlca_pkg::node_t b;
    roll = $urandom_range(99);
    if (roll < 45) begin
      b = $urandom_range(1) ? pick_recent() : pick_placed();
      a = pick_fresh();
      if (a == '0) a = pick_placed();
      send_word(tlca_pkg::REQ_INSERT, a, b);
    end else if (roll < 52) begin
      a = pick_placed();
      b = (roll < 48) ? a : pick_placed();
      send_word(tlca_pkg::REQ_INSERT, a, b);
    end else begin
      a = $urandom_range(1) ? pick_recent() : pick_placed();
      b = ($urandom_range(9) == 0) ? tlca_pkg::ROOT_NODE : pick_placed();
      if ($urandom_range(1)) send_word(tlca_pkg::REQ_QUERY, a, b);
      else send_word(tlca_pkg::REQ_QUERY, b, a);
    end
  endtask

  initial begin
    tlca_pkg::node_t deep_node;
    placed[0] = 1'b1;
    placed[1] = 1'b1;
    placed_q  = {placed_q, tlca_pkg::ROOT_NODE};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words: root queries, a small tree, an ignored root insert,
    // extreme node numbers, a self parent and a cycle.
    send_word(tlca_pkg::REQ_QUERY, 1, 1);
    send_word(tlca_pkg::REQ_INSERT, 2, 1);
    send_word(tlca_pkg::REQ_INSERT, 3, 2);
    send_word(tlca_pkg::REQ_INSERT, 4, 2);
    send_word(tlca_pkg::REQ_INSERT, 5, 3);
    send_word(tlca_pkg::REQ_QUERY, 5, 4);
    send_word(tlca_pkg::REQ_QUERY, 4, 5);
    send_word(tlca_pkg::REQ_QUERY, 5, 5);
    send_word(tlca_pkg::REQ_QUERY, 1, 5);
    send_word(tlca_pkg::REQ_QUERY, 5, 1);
    send_word(tlca_pkg::REQ_INSERT, 1, 5);
    send_word(tlca_pkg::REQ_QUERY, 5, 1);
    send_word(tlca_pkg::REQ_INSERT, 1023, 5);
    send_word(tlca_pkg::REQ_INSERT, 512, 1023);
    send_word(tlca_pkg::REQ_QUERY, 1023, 512);
    send_word(tlca_pkg::REQ_QUERY, 512, 4);
    send_word(tlca_pkg::REQ_INSERT, 682, 1);
    send_word(tlca_pkg::REQ_INSERT, 341, 682);
    send_word(tlca_pkg::REQ_QUERY, 341, 512);
    send_word(tlca_pkg::REQ_INSERT, 4, 4);
    send_word(tlca_pkg::REQ_QUERY, 4, 3);
    send_word(tlca_pkg::REQ_INSERT, 2, 5);
    send_word(tlca_pkg::REQ_QUERY, 5, 4);
    send_word(tlca_pkg::REQ_QUERY, 3, 1023);
    send_word(tlca_pkg::REQ_QUERY, 341, 2);
    drain();

    // Random words in three idling phases, with a long receiver hold-off
    // under a steady burst and a full drain on the way.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 3) begin
        send_idle_pct = 87;
        recv_idle_pct = 23;
      end
      if (i == 2 * RANDOM_WORDS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i == 100) stall_asks++;
      if (i == 450) drain();
      if (i < 100 || i >= 160) maybe_idle();
      random_word();
    end

    // Deepen one node by hanging it under itself again and again,
    // then give it children and query around it.
    deep_node = pick_fresh();
    if (deep_node == '0) deep_node = pick_placed();
    if (deep_node == tlca_pkg::ROOT_NODE) deep_node = 1000;
    send_word(tlca_pkg::REQ_INSERT, deep_node, pick_recent());
    for (int i = 0; i < SELF_INSERTS; i++) begin
      send_word(tlca_pkg::REQ_INSERT, deep_node, deep_node);
      if (i % 20 == 19) send_word(tlca_pkg::REQ_QUERY, deep_node, pick_placed());
    end
    for (int i = 0; i < 20; i++) begin
      send_word(tlca_pkg::REQ_INSERT, pick_placed(), deep_node);
      send_word(tlca_pkg::REQ_QUERY, pick_recent(), pick_placed());
      send_word(tlca_pkg::REQ_QUERY, tlca_pkg::ROOT_NODE, deep_node);
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    sb.errors += sb.pending();
    $display("Sent %0d inserts and %0d distance queries; %0d answers checked.",
             insert_words, query_words, sb.checked);
    $display("Deepest node depth reached: %0d.", sb.deepest);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
